/* hdl/ucor_pkg.sv */
// Package for the unified CORDIC engine: widths, opcodes, stage payload type,
// the per-cell step plan and the atan/atanh angle tables built at elaboration.
// Depends on nothing.
`default_nettype none

package ucor_pkg;

  localparam int unsigned FB = 16;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned OP_W = 3;
  localparam int unsigned NUM_CELLS = FB + 2;
  localparam int unsigned STAGE_W = $clog2(NUM_CELLS);
  localparam int unsigned SHIFT_W = $clog2(FB + 1);
  localparam logic [63:0] PI_TIMES_2_60 = 64'h3243F6A8885A308D;

  typedef enum logic [OP_W-1:0] {
    OP_CIRC_ROT = 3'd0,
    OP_CIRC_VEC = 3'd1,
    OP_HYP_ROT  = 3'd2,
    OP_HYP_VEC  = 3'd3,
    OP_LIN_ROT  = 3'd4,
    OP_LIN_VEC  = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    MODE_CIRC,
    MODE_HYP,
    MODE_LIN
  } mode_e;

  typedef struct packed {
    logic [OP_W-1:0]          opcode;
    logic signed [DATA_W-1:0] x;
    logic signed [DATA_W-1:0] y;
    logic signed [DATA_W-1:0] z;
  } stage_t;

  typedef struct packed {
    logic               active;
    logic               vector;
    mode_e              mode;
    logic [SHIFT_W-1:0] shift;
  } plan_t;

  typedef logic [FB:0][DATA_W-1:0] rom_t;

  function automatic int unsigned series_len(int unsigned i);
    case (i)
      1:       return 27;
      2:       return 14;
      3:       return 9;
      4:       return 7;
      5:       return 5;
      6:       return 4;
      7:       return 4;
      8:       return 3;
      9:       return 3;
      10:      return 3;
      default: return 0;
    endcase
  endfunction

  function automatic logic [63:0] recip_round(logic [63:0] n);
    logic [63:0] rem;
    logic [63:0] q;
    rem = 64'd1;
    q = 64'd0;
    for (int i = 0; i <= int'(FB); i++) begin
      q = q + q;
      if (rem >= n) begin
        q = q + 64'd1;
        rem = rem - n;
      end
      rem = rem + rem;
    end
    return (rem >= n) ? q + 64'd1 : q;
  endfunction

  function automatic logic [63:0] series_coef(int unsigned k, logic alternate);
    logic [63:0] c;
    c = 64'd0;
    if ((k % 2) == 1) begin
      c = recip_round(64'(k));
      if (alternate && ((k % 4) == 3)) begin
        c = 64'd0 - c;
      end
    end
    return c;
  endfunction

  function automatic logic [63:0] series_eval(int unsigned i, logic alternate);
    logic [63:0] r;
    r = 64'd0;
    for (int k = int'(series_len(i)); k >= 0; k--) begin
      r = $unsigned($signed(r) >>> i) + series_coef(k, alternate);
    end
    return r;
  endfunction

  function automatic rom_t build_rom(logic circular);
    rom_t        rom;
    logic [63:0] half_pi;
    half_pi = ((PI_TIMES_2_60 >> (60 - FB)) + 64'd1) >> 1;
    for (int unsigned i = 0; i <= FB; i++) begin
      if (i == 0) begin
        rom[i] = circular ? half_pi[DATA_W:1] : '0;
      end else if (i <= 10) begin
        rom[i] = DATA_W'(series_eval(i, circular));
      end else begin
        rom[i] = DATA_W'(1) << (FB - i);
      end
    end
    return rom;
  endfunction

  localparam rom_t ATAN_ROM = build_rom(1'b1);
  localparam rom_t ATANH_ROM = build_rom(1'b0);

  function automatic plan_t step_plan(logic [OP_W-1:0] opcode, logic [STAGE_W-1:0] stage);
    plan_t       p;
    int unsigned k;
    k = int'(stage);
    p.active = 1'b0;
    p.vector = 1'b0;
    p.mode = MODE_CIRC;
    p.shift = '0;
    case (opcode)
      OP_CIRC_ROT, OP_CIRC_VEC: begin
        p.active = (k <= FB);
        p.vector = (opcode == OP_CIRC_VEC);
        p.mode = MODE_CIRC;
        p.shift = SHIFT_W'(k);
      end
      OP_HYP_ROT, OP_HYP_VEC: begin
        p.active = 1'b1;
        p.vector = (opcode == OP_HYP_VEC);
        p.mode = MODE_HYP;
        if (k < 4) begin
          p.shift = SHIFT_W'(k + 1);
        end else if (k <= 13) begin
          p.shift = SHIFT_W'(k);
        end else begin
          p.shift = SHIFT_W'(k - 1);
        end
      end
      OP_LIN_ROT, OP_LIN_VEC: begin
        p.active = (k < FB);
        p.vector = (opcode == OP_LIN_VEC);
        p.mode = MODE_LIN;
        p.shift = SHIFT_W'(k + 1);
      end
      default: begin
        p.active = 1'b0;
      end
    endcase
    return p;
  endfunction

endpackage

`default_nettype wire

/* hdl/ucor_in_if.sv */
// Input channel of the CORDIC engine: valid/ready handshake with opcode and
// initial x, y, z. Depends on ucor_pkg for widths.
`default_nettype none

interface ucor_in_if;
  logic                               valid;
  logic                               ready;
  logic [ucor_pkg::OP_W-1:0]          opcode;
  logic signed [ucor_pkg::DATA_W-1:0] x_in;
  logic signed [ucor_pkg::DATA_W-1:0] y_in;
  logic signed [ucor_pkg::DATA_W-1:0] z_in;

  modport source (output valid, output opcode, output x_in, output y_in, output z_in,
                  input ready);
  modport sink (input valid, input opcode, input x_in, input y_in, input z_in,
                output ready);
endinterface

`default_nettype wire

/* hdl/ucor_out_if.sv */
// Output channel of the CORDIC engine: valid/ready handshake with final x, y, z.
// Depends on ucor_pkg for widths.
`default_nettype none

interface ucor_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [ucor_pkg::DATA_W-1:0] x_out;
  logic signed [ucor_pkg::DATA_W-1:0] y_out;
  logic signed [ucor_pkg::DATA_W-1:0] z_out;

  modport source (output valid, output x_out, output y_out, output z_out, input ready);
  modport sink (input valid, input x_out, input y_out, input z_out, output ready);
endinterface

`default_nettype wire

/* hdl/unified_cordic_engine.sv */
// Unified CORDIC engine, top level: a chain of micro-rotation cells followed
// by an output register with a spare entry.
// Depends on ucor_pkg, ucor_in_if, ucor_out_if, ucor_cell and ucor_skid.
//
// Usage:
//   The in_i channel takes one transaction per cycle while in_i.ready is
//   high: an opcode (circular, hyperbolic or linear, each rotating or
//   vectoring) and initial x, y, z. The out_o channel returns one
//   transaction with the final x, y, z for each input, in order. Opcodes
//   6 and 7 pass x, y, z through unchanged. The chain has 18 cells for
//   16 fraction bits, then the output register; throughput is one
//   transaction per cycle while out_o.ready is high: one cell per step.
//   No gain correction is applied: prescaling is left to the caller.
//   Reset clears all valid flags at once; the angle tables are constants.
//   When the receiver stalls, the output register holds its transaction and
//   a spare entry takes one more; the chain then fills up cell by cell and
//   in_i.ready falls only once the first cell is occupied and blocked.
`default_nettype none

module unified_cordic_engine (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  ucor_in_if.sink    in_i,
  ucor_out_if.source out_o
);

  localparam int unsigned N = ucor_pkg::NUM_CELLS;

  logic             valid_w [N+1];
  logic             ready_w [N+1];
  ucor_pkg::stage_t data_w  [N+1];
  ucor_pkg::stage_t out_data;

  assign valid_w[0] = in_i.valid;
  assign in_i.ready = ready_w[0];
  assign data_w[0].opcode = in_i.opcode;
  assign data_w[0].x = in_i.x_in;
  assign data_w[0].y = in_i.y_in;
  assign data_w[0].z = in_i.z_in;

  for (genvar k = 0; k < N; k++) begin : g_cell
    ucor_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .stage_i     (ucor_pkg::STAGE_W'(k)),
      .in_valid_i  (valid_w[k]),
      .in_data_i   (data_w[k]),
      .in_ready_o  (ready_w[k]),
      .out_valid_o (valid_w[k+1]),
      .out_data_o  (data_w[k+1]),
      .out_ready_i (ready_w[k+1])
    );
  end

  ucor_skid u_skid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (valid_w[N]),
    .in_data_i   (data_w[N]),
    .in_ready_o  (ready_w[N]),
    .out_valid_o (out_o.valid),
    .out_data_o  (out_data),
    .out_ready_i (out_o.ready)
  );

  assign out_o.x_out = out_data.x;
  assign out_o.y_out = out_data.y;
  assign out_o.z_out = out_data.z;

  a_first_cell_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> valid_w[1])
    else $error("An accepted transaction did not reach the first cell.");

  a_ready_tracks_chain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!valid_w[1]) |-> in_i.ready)
    else $error("Input not ready although the first cell is empty.");

endmodule

`default_nettype wire

/* hdl/ucor_cell.sv */
// One CORDIC micro-rotation cell: applies the step that its position in the
// chain holds for the item's mode, then registers the result. Uses ucor_pkg.
`default_nettype none

module ucor_cell (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic [ucor_pkg::STAGE_W-1:0] stage_i,
  input  wire logic                         in_valid_i,
  input  wire ucor_pkg::stage_t             in_data_i,
  output logic                              in_ready_o,
  output logic                              out_valid_o,
  output ucor_pkg::stage_t                  out_data_o,
  input  wire logic                         out_ready_i
);

  localparam logic [ucor_pkg::SHIFT_W-1:0] SHIFT_W_FB = ucor_pkg::SHIFT_W'(ucor_pkg::FB);

  ucor_pkg::plan_t                    plan;
  logic signed [ucor_pkg::DATA_W-1:0] xs;
  logic signed [ucor_pkg::DATA_W-1:0] ys;
  logic [ucor_pkg::DATA_W-1:0]        ang;
  logic                               pos;
  ucor_pkg::stage_t                   data_d;
  ucor_pkg::stage_t                   data_q;
  logic                               valid_q;
  logic                               load;

  assign in_ready_o = !valid_q || out_ready_i;
  assign load = in_valid_i && in_ready_o;

  always_comb begin
    plan = ucor_pkg::step_plan(in_data_i.opcode, stage_i);
    xs = in_data_i.x >>> plan.shift;
    ys = in_data_i.y >>> plan.shift;
    pos = plan.vector ? (in_data_i.y[ucor_pkg::DATA_W-1] || (in_data_i.y == '0))
                      : !in_data_i.z[ucor_pkg::DATA_W-1];
    data_d = in_data_i;
    case (plan.mode)
      ucor_pkg::MODE_CIRC: ang = ucor_pkg::ATAN_ROM[plan.shift];
      ucor_pkg::MODE_HYP:  ang = ucor_pkg::ATANH_ROM[plan.shift];
      default:             ang = ucor_pkg::DATA_W'(1) << (SHIFT_W_FB - plan.shift);
    endcase
    if (plan.active) begin
      case (plan.mode)
        ucor_pkg::MODE_CIRC: begin
          data_d.x = pos ? in_data_i.x - ys : in_data_i.x + ys;
          data_d.y = pos ? in_data_i.y + xs : in_data_i.y - xs;
        end
        ucor_pkg::MODE_HYP: begin
          data_d.x = pos ? in_data_i.x + ys : in_data_i.x - ys;
          data_d.y = pos ? in_data_i.y + xs : in_data_i.y - xs;
        end
        default: begin
          data_d.y = pos ? in_data_i.y + xs : in_data_i.y - xs;
        end
      endcase
      data_d.z = pos ? in_data_i.z - $signed(ang) : in_data_i.z + $signed(ang);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= data_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o = data_q;

endmodule

`default_nettype wire

/* hdl/ucor_skid.sv */
// Output register with a spare entry, so the cell chain sees a registered
// ready and keeps moving while a result waits. Uses ucor_pkg.
`default_nettype none

module ucor_skid (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  input  wire ucor_pkg::stage_t in_data_i,
  output logic                  in_ready_o,
  output logic                  out_valid_o,
  output ucor_pkg::stage_t      out_data_o,
  input  wire logic             out_ready_i
);

  logic             main_v_q;
  logic             spare_v_q;
  ucor_pkg::stage_t main_q;
  ucor_pkg::stage_t spare_q;
  logic             in_fire;
  logic             advance;

  assign in_ready_o = !spare_v_q;
  assign in_fire = in_valid_i && in_ready_o;
  assign advance = out_ready_i || !main_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_v_q <= 1'b0;
      spare_v_q <= 1'b0;
    end else if (advance) begin
      main_v_q <= spare_v_q || in_fire;
      spare_v_q <= 1'b0;
    end else if (in_fire) begin
      spare_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      main_q <= spare_v_q ? spare_q : in_data_i;
    end else if (in_fire) begin
      spare_q <= in_data_i;
    end
  end

  assign out_valid_o = main_v_q;
  assign out_data_o = main_q;

  a_spare_needs_main: assert property (@(posedge clk_i) disable iff (!rst_ni)
    spare_v_q |-> main_v_q)
    else $error("Spare entry holds a transaction while the output register is empty.");

  a_stall_fills_spare: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && main_v_q && !out_ready_i) |=> (spare_v_q && main_v_q))
    else $error("A transaction taken during a stall did not land in the spare entry.");

  a_spare_drains_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (spare_v_q && out_ready_i) |=> (main_v_q && (main_q == $past(spare_q))))
    else $error("The spare entry was not moved into the output register.");

endmodule

`default_nettype wire
